// ----- rtl/lpmd_pkg.sv -----
// Shared types and constants for the length-prefixed message deframer.
`default_nettype none

package lpmd_pkg;

  localparam int unsigned ID_W   = 16;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned LEN_W  = 16;

  localparam logic [LEN_W-1:0] LENGTH_LIMIT_RESET = 16'd2048;

  // Stream phase codes.
  localparam logic [1:0] PH_HEADER  = 2'd0;
  localparam logic [1:0] PH_PAYLOAD = 2'd1;
  localparam logic [1:0] PH_CLOSED  = 2'd2;

  typedef struct packed {
    logic [ID_W-1:0]   message_id;
    logic [BYTE_W-1:0] payload_byte;
    logic              payload_valid;
    logic              last;
    logic              length_error;
  } res_t;

endpackage

`default_nettype wire

// ----- rtl/lpmd_core.sv -----
// Header collection, length check and payload tagging, one byte per cycle on accept.
`default_nettype none

module lpmd_core #(
  parameter int unsigned HEADER_BYTES = 4,
  parameter int unsigned ID_BYTES     = 2
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_write,
  input  wire logic [15:0]               cfg_data,
  input  wire logic                      accept,
  input  wire logic [7:0]                rx_byte,
  output logic                           res_valid,
  output lpmd_pkg::res_t                 res
);
  import lpmd_pkg::*;

  localparam int unsigned CNT_W = $clog2(HEADER_BYTES);
  localparam int unsigned ID_LIM_I = (ID_BYTES > HEADER_BYTES) ? HEADER_BYTES : ID_BYTES;
  localparam logic [CNT_W:0]   ID_LIM   = (CNT_W + 1)'(ID_LIM_I);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(HEADER_BYTES - 1);

  logic [LEN_W-1:0]  length_limit;
  logic [1:0]        phase;
  logic [1:0]        phase_next;
  logic [CNT_W-1:0]  header_count;
  logic [CNT_W-1:0]  header_count_next;
  logic [LEN_W-1:0]  header_shift;
  logic [LEN_W-1:0]  header_shift_next;
  logic [ID_W-1:0]   current_id;
  logic [ID_W-1:0]   current_id_next;
  logic [LEN_W-1:0]  bytes_remaining;
  logic [LEN_W-1:0]  bytes_remaining_next;

  logic [ID_W-1:0]   id_shifted;
  logic [LEN_W-1:0]  len_shifted;
  logic [LEN_W-1:0]  remaining_dec;
  logic              in_id_field;

  assign in_id_field   = {1'b0, header_count} < ID_LIM;
  assign id_shifted    = in_id_field ? {current_id[ID_W-BYTE_W-1:0], rx_byte} : current_id;
  assign len_shifted   = in_id_field ? header_shift : {header_shift[LEN_W-BYTE_W-1:0], rx_byte};
  assign remaining_dec = bytes_remaining - LEN_W'(1);

  always_comb begin
    phase_next           = phase;
    header_count_next    = header_count;
    header_shift_next    = header_shift;
    current_id_next      = current_id;
    bytes_remaining_next = bytes_remaining;
    res_valid            = 1'b0;
    res                  = '0;
    unique case (phase)
      PH_HEADER: begin
        current_id_next   = id_shifted;
        header_shift_next = len_shifted;
        header_count_next = header_count + CNT_W'(1);
        res.message_id    = id_shifted;
        if (header_count == CNT_LAST) begin
          header_count_next = '0;
          if (len_shifted > length_limit) begin
            // Oversize length: report once and close the stream until reset.
            phase_next           = PH_CLOSED;
            bytes_remaining_next = '0;
            res_valid            = 1'b1;
            res.length_error     = 1'b1;
          end else if (len_shifted == '0) begin
            res_valid         = 1'b1;
            res.last          = 1'b1;
            current_id_next   = '0;
            header_shift_next = '0;
          end else begin
            bytes_remaining_next = len_shifted;
            header_shift_next    = '0;
            phase_next           = PH_PAYLOAD;
          end
        end
      end
      PH_PAYLOAD: begin
        bytes_remaining_next = remaining_dec;
        res_valid            = 1'b1;
        res.message_id       = current_id;
        res.payload_byte     = rx_byte;
        res.payload_valid    = 1'b1;
        res.last             = (remaining_dec == '0);
        if (remaining_dec == '0) begin
          phase_next        = PH_HEADER;
          header_count_next = '0;
          header_shift_next = '0;
          current_id_next   = '0;
        end
      end
      PH_CLOSED: begin
      end
      default: begin
        phase_next = PH_CLOSED;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      length_limit    <= LENGTH_LIMIT_RESET;
      phase           <= PH_HEADER;
      header_count    <= '0;
      header_shift    <= '0;
      current_id      <= '0;
      bytes_remaining <= '0;
    end else begin
      if (cfg_write) begin
        length_limit <= cfg_data;
      end
      if (accept) begin
        phase           <= phase_next;
        header_count    <= header_count_next;
        header_shift    <= header_shift_next;
        current_id      <= current_id_next;
        bytes_remaining <= bytes_remaining_next;
      end
    end
  end

endmodule

`default_nettype wire

// ----- rtl/lpmd_out_buf.sv -----
// Output register with a skid stage so that the input stall is registered.
`default_nettype none

module lpmd_out_buf (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           res_valid,
  input  wire lpmd_pkg::res_t res,
  output logic                full,
  output logic                out_valid,
  input  wire logic           out_stall,
  output lpmd_pkg::res_t      out_res
);
  import lpmd_pkg::*;

  logic skid_valid;
  res_t skid_res;
  logic out_free;

  assign full     = skid_valid;
  assign out_free = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (out_free) begin
      if (skid_valid) begin
        out_valid  <= 1'b1;
        skid_valid <= 1'b0;
      end else begin
        out_valid <= res_valid;
      end
    end else if (res_valid) begin
      skid_valid <= 1'b1;
    end
  end

  // Payload registers; no input arrives while the skid stage is occupied.
  always_ff @(posedge clk) begin
    if (out_free) begin
      out_res <= skid_valid ? skid_res : res;
    end else if (res_valid) begin
      skid_res <= res;
    end
  end

endmodule

`default_nettype wire

// ----- rtl/length_prefixed_message_deframer_unit.sv -----
// Top level of the length-prefixed message deframer.
//
// Input channel: one received byte per transfer on rx_byte, qualified by
// in_valid and held off by in_stall. Each message is a header of
// HEADER_BYTES bytes (big-endian id in the first ID_BYTES, then big-endian
// length) followed by that many payload bytes.
// Output channel: one result per payload byte, tagged with message_id and
// marked last on the final byte. An empty message gives one result with
// payload_valid low and last high. A length above the length limit gives one
// result with length_error high, after which every byte is dropped.
// Throughput is one byte per cycle while in_stall is low; header bytes give no
// result but in those two cases. Results are registered at the output.
// When the receiver stalls, one further result is held in a skid stage and
// in_stall rises in the next cycle; it falls once the skid stage drains.
// cfg_write loads the length limit (2048 after reset) and takes effect from
// the next completed header. Reset returns the block to the start of a header,
// reopens a closed stream and empties the output stages.
`default_nettype none

module length_prefixed_message_deframer_unit #(
  parameter int unsigned HEADER_BYTES = 4,
  parameter int unsigned ID_BYTES     = 2
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        cfg_write,
  input  wire logic [15:0] cfg_data,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  rx_byte,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [15:0]      message_id,
  output logic [7:0]       payload_byte,
  output logic             payload_valid,
  output logic             last,
  output logic             length_error
);
  import lpmd_pkg::*;

  logic accept;
  logic res_valid;
  res_t res;
  res_t out_res;
  logic buf_full;

  assign in_stall = buf_full;
  assign accept   = in_valid && !buf_full;

  lpmd_core #(
    .HEADER_BYTES (HEADER_BYTES),
    .ID_BYTES     (ID_BYTES)
  ) u_core (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_data  (cfg_data),
    .accept    (accept),
    .rx_byte   (rx_byte),
    .res_valid (res_valid),
    .res       (res)
  );

  lpmd_out_buf u_out_buf (
    .clk       (clk),
    .rst       (rst),
    .res_valid (res_valid && accept),
    .res       (res),
    .full      (buf_full),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_res   (out_res)
  );

  assign message_id    = out_res.message_id;
  assign payload_byte  = out_res.payload_byte;
  assign payload_valid = out_res.payload_valid;
  assign last          = out_res.last;
  assign length_error  = out_res.length_error;

endmodule

`default_nettype wire
